// ===== rtl/hrrn_pkg.sv =====
// Package with shared constants and codes for the ready-queue scheduler.
package hrrn_pkg;
  localparam int ENTRIES_DEF   = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int PID_W   = 16;
  localparam int EST_W   = 16;
  localparam int ORDER_W = 32;
  localparam int CNT_W   = 5;
  localparam int ALPHA_W = 9;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_INSERT   = 2'd1,
    CMD_SCHEDULE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_ALPHA  = 2'd1;
endpackage

// ===== rtl/hrrn_if.sv =====
// Stream interfaces for the command and result channels.
interface hrrn_cmd_if import hrrn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       command;
  logic [PID_W-1:0] proc_id;
  logic [EST_W-1:0] prior_estimate;
  logic [EST_W-1:0] last_burst;
  logic             has_run;
  modport source (output valid, command, proc_id, prior_estimate, last_burst, has_run,
                  input ready);
  modport sink   (input valid, command, proc_id, prior_estimate, last_burst, has_run,
                  output ready);
endinterface

interface hrrn_res_if import hrrn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [PID_W-1:0] chosen_pid;
  logic [EST_W-1:0] chosen_estimate;
  logic [CNT_W-1:0] ready_count;
  modport source (output valid, status, chosen_pid, chosen_estimate, ready_count,
                  input ready);
  modport sink   (input valid, status, chosen_pid, chosen_estimate, ready_count,
                  output ready);
endinterface

// ===== rtl/hrrn_ready_queue_scheduler.sv =====
// Top level of the highest-response-ratio-next ready-queue scheduler.
// Tick: S_OUT registers the result. Insert: S_EST registers the estimate products,
// S_WRITE writes the slot, then S_OUT. Schedule: the slot memory is read one entry
// a cycle and each candidate is compared with the best so far in the cycle after its
// read data arrives. One word is in flight at a time; the next word is taken only after
// the result is accepted. Synchronous reset clears valid bits, time and order counter,
// sets policy mode to 1 and alpha weight to 128; the slot memory itself is not cleared.
module hrrn_ready_queue_scheduler import hrrn_pkg::*; #(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hrrn_cmd_if.sink    cmd,
  hrrn_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int SW = EST_W + PID_W + TIME_BITS + ORDER_W;
  localparam int PW = TIME_BITS + EST_W;

  typedef enum logic [2:0] {
    S_IDLE, S_EST, S_WRITE, S_SCAN, S_CMP, S_DECIDE, S_OUT
  } state_t;

  state_t state;
  logic policy_mode;
  logic [ALPHA_W-1:0] alpha_weight;
  logic [ENTRIES-1:0] slot_valid;
  logic [TIME_BITS-1:0] time_now;
  logic [ORDER_W-1:0] order_counter;
  logic first_pick_pending;

  logic [PID_W-1:0] pid_r;
  logic [EST_W-1:0] prior_r, burst_r;
  logic ran_r;
  logic [EST_W+ALPHA_W-1:0] prod_a, prod_b;

  logic we;
  logic [IW-1:0] waddr, raddr, rd_idx;
  logic [SW-1:0] wdata, rdata;
  logic [CW-1:0] scan_cnt;
  logic rd_live;

  logic found, by_ratio;
  logic [IW-1:0] best;
  logic [EST_W-1:0] best_est;
  logic [PID_W-1:0] best_pid;
  logic [TIME_BITS-1:0] best_wait;
  logic [ORDER_W-1:0] best_age;
  logic [EST_W-1:0] c_est;
  logic [PID_W-1:0] c_pid;
  logic [TIME_BITS-1:0] c_wait;
  logic [ORDER_W-1:0] c_age;
  logic [IW-1:0] c_idx;
  logic c_live;
  logic [PW-1:0] lx, ly;

  logic [1:0] status_r;
  logic [PID_W-1:0] cpid_r;
  logic [EST_W-1:0] cest_r;

  logic [IW-1:0] free_idx;
  logic full;
  logic [CW-1:0] count;
  logic [ALPHA_W-1:0] a_sat;
  logic [EST_W+ALPHA_W:0] est_sum;
  logic [EST_W-1:0] est_new;
  logic cfg_wr;

  hrrn_ram #(.WIDTH(SW), .DEPTH(ENTRIES)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_comb begin
    free_idx = '0;
    full = 1'b1;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx = IW'(i);
        full = 1'b0;
      end
    end
    count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      count = count + CW'(slot_valid[i]);
    end
  end

  assign a_sat   = (alpha_weight > ALPHA_W'(256)) ? ALPHA_W'(256) : alpha_weight;
  assign est_sum = (EST_W+ALPHA_W+1)'(prod_a) + (EST_W+ALPHA_W+1)'(prod_b);
  assign est_new = (est_sum[EST_W+7:8] == '0) ? EST_W'(1) : est_sum[EST_W+7:8];

  assign lx = PW'(c_wait) * PW'(best_est);
  assign ly = PW'(best_wait) * PW'(c_est);

  assign we    = (state == S_WRITE);
  assign waddr = free_idx;
  assign wdata = {est_new, pid_r, time_now, order_counter};
  assign raddr = scan_cnt[IW-1:0];

  assign cmd.ready = (state == S_IDLE) && !res.valid;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ALPHA[0]) ? 32'(alpha_weight) : 32'(policy_mode);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      policy_mode <= 1'b1;
      alpha_weight <= ALPHA_W'(128);
      slot_valid <= '0;
      time_now <= '0;
      order_counter <= '0;
      first_pick_pending <= 1'b1;
      res.valid <= 1'b0;
      rd_live <= 1'b0;
      c_live <= 1'b0;
      found <= 1'b0;
      scan_cnt <= '0;
    end else begin
      if (cfg_wr && paddr == 3'(4 * REG_POLICY)) begin
        policy_mode <= pwdata[0];
      end
      if (cfg_wr && paddr == 3'(4 * REG_ALPHA)) begin
        alpha_weight <= pwdata[ALPHA_W-1:0];
      end
      if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid && cmd.ready) begin
            pid_r <= cmd.proc_id;
            prior_r <= cmd.prior_estimate;
            burst_r <= cmd.last_burst;
            ran_r <= cmd.has_run;
            status_r <= ST_DONE;
            cpid_r <= '0;
            cest_r <= '0;
            case (cmd.command)
              CMD_TICK: begin
                time_now <= time_now + 1'b1;
                state <= S_OUT;
              end
              CMD_INSERT: begin
                if (full) begin
                  status_r <= ST_FULL;
                  state <= S_OUT;
                end else begin
                  state <= S_EST;
                end
              end
              CMD_SCHEDULE: begin
                if (slot_valid == '0) begin
                  status_r <= ST_EMPTY;
                  state <= S_OUT;
                end else begin
                  by_ratio <= policy_mode && !first_pick_pending;
                  found <= 1'b0;
                  scan_cnt <= '0;
                  rd_live <= 1'b0;
                  c_live <= 1'b0;
                  state <= S_SCAN;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_EST: begin
          if (ran_r) begin
            prod_a <= (EST_W+ALPHA_W)'(a_sat) * (EST_W+ALPHA_W)'(burst_r);
            prod_b <= (EST_W+ALPHA_W)'(ALPHA_W'(256) - a_sat) * (EST_W+ALPHA_W)'(prior_r);
          end else begin
            prod_a <= '0;
            prod_b <= (EST_W+ALPHA_W)'({prior_r, 8'd0});
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          slot_valid[free_idx] <= 1'b1;
          order_counter <= order_counter + 1'b1;
          state <= S_OUT;
        end
        S_SCAN: begin
          // Stage 1: issue read; stage 2: unpack; stage 3: compare with the best so far.
          rd_live <= (scan_cnt < CW'(ENTRIES)) && slot_valid[raddr];
          rd_idx <= raddr;
          if (scan_cnt < CW'(ENTRIES)) begin
            scan_cnt <= scan_cnt + 1'b1;
          end
          c_live <= rd_live;
          c_idx <= rd_idx;
          c_est <= rdata[SW-1 -: EST_W];
          c_pid <= rdata[SW-EST_W-1 -: PID_W];
          c_wait <= time_now - rdata[ORDER_W +: TIME_BITS];
          c_age <= order_counter - rdata[ORDER_W-1:0];
          if (c_live) begin
            if (!found || (by_ratio && lx != ly && lx > ly)
                || ((!by_ratio || lx == ly) && c_age > best_age)) begin
              found <= 1'b1;
              best <= c_idx;
              best_est <= c_est;
              best_pid <= c_pid;
              best_wait <= c_wait;
              best_age <= c_age;
            end
          end
          if (scan_cnt == CW'(ENTRIES) && !rd_live && !c_live) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          cpid_r <= best_pid;
          cest_r <= best_est;
          slot_valid[best] <= 1'b0;
          if (policy_mode) begin
            first_pick_pending <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          res.valid <= 1'b1;
          res.status <= status_r;
          res.chosen_pid <= cpid_r;
          res.chosen_estimate <= cest_r;
          res.ready_count <= CNT_W'(count);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE) |-> slot_valid[best])
    else $error("chosen slot is not valid");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> !full)
    else $error("insert write into full table");
  assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !res.valid)
    else $error("new word accepted while result pending");
endmodule

// ===== rtl/hrrn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hrrn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
